@@ src/heading_error_haptic_cue_core_defines.svh @@
// Assertion macros shared by the heading error cue block.
`ifndef HEADING_ERROR_HAPTIC_CUE_CORE_DEFINES_SVH
`define HEADING_ERROR_HAPTIC_CUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only while reset is released.
`define HECC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("heading error cue assertion failed");
// Checked at every edge, reset included.
`define HECC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("heading error cue assertion failed");
`else
`define HECC_ASSERT(lbl, prop)
`define HECC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ src/hecc_pkg.sv @@
// Types, constants and tables of the heading error cue block.
package hecc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANG_PI       = 205887;
    localparam int ANG_TWO_PI   = 411775;
    localparam int ANG_HALF_PI  = 102944;

    localparam int CW      = 34;  // CORDIC input vector width
    localparam int XW      = 37;  // CORDIC working width
    localparam int ZW      = 21;  // angle accumulator width
    localparam int DW      = 22;  // angle difference width
    localparam int STEP_W  = 5;
    localparam int QW      = 9;   // width of the scaled magnitude before the clamp
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Half pi is 32 * 3217. After the low five bits are dropped, the division
    // by 3217 is a multiply by ceil(2^33 / 3217) and a shift by 33, which is
    // exact for every dividend below 2^21.
    localparam logic [21:0] DIV_RECIP = 22'd2670170;
    localparam int          DIV_SHIFT = 33;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_IDX     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_IDX    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_PRES    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PRES   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 8'd5;

    localparam logic [1:0] CUE_NONE  = 2'd0;
    localparam logic [1:0] CUE_LEFT  = 2'd1;
    localparam logic [1:0] CUE_RIGHT = 2'd2;

    typedef struct packed {
        logic               have_target;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic        [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic signed [8:0] haptic_level;
        logic        [7:0] sound_index;
        logic              cue_fired;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CINIT,
        ST_CITER,
        ST_DELTA,
        ST_WRAP,
        ST_DINIT,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic              load;
        logic              mul_en;
        logic [1:0]        mul_sel;
        logic              cord_init;
        logic              cord_sel;
        logic              cord_step;
        logic [STEP_W-1:0] cord_idx;
        logic              delta_en;
        logic              wrap_en;
        logic              div_init;
        logic              div_step;
        logic              finish;
    } cmd_t;

    typedef struct packed {
        logic wrap_ok;
        logic out_free;
    } sts_t;

    // atan(2^-i) in Q16, rounded to nearest.
    function automatic logic [16:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:  v = 17'd51472;
            5'd1:  v = 17'd30386;
            5'd2:  v = 17'd16055;
            5'd3:  v = 17'd8150;
            5'd4:  v = 17'd4091;
            5'd5:  v = 17'd2047;
            5'd6:  v = 17'd1024;
            5'd7:  v = 17'd512;
            5'd8:  v = 17'd256;
            5'd9:  v = 17'd128;
            5'd10: v = 17'd64;
            5'd11: v = 17'd32;
            5'd12: v = 17'd16;
            5'd13: v = 17'd8;
            5'd14: v = 17'd4;
            5'd15: v = 17'd2;
            5'd16: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/hecc_ctrl.sv @@
// Sequencer of the heading error cue block.
`include "heading_error_haptic_cue_core_defines.svh"
module hecc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hecc_pkg::sts_t sts,
    output hecc_pkg::cmd_t cmd
);
    import hecc_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(3))
                begin
                    state_next = ST_CINIT;
                    sel_next   = 1'b0;
                end
            end
            ST_CINIT:
            begin
                state_next = ST_CITER;
                cnt_next   = '0;
            end
            ST_CITER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    if (sel_reg)
                    begin
                        state_next = ST_DELTA;
                    end
                    else
                    begin
                        state_next = ST_CINIT;
                        sel_next   = 1'b1;
                    end
                end
            end
            ST_DELTA: state_next = ST_WRAP;
            ST_WRAP:
            begin
                if (sts.wrap_ok)
                begin
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: state_next = ST_DIV;
            ST_DIV:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        cmd.mul_sel  = cnt_reg[1:0];
        cmd.cord_idx = cnt_reg;
        cmd.cord_sel = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL:   cmd.mul_en    = 1'b1;
            ST_CINIT: cmd.cord_init = 1'b1;
            ST_CITER: cmd.cord_step = 1'b1;
            ST_DELTA: cmd.delta_en  = 1'b1;
            ST_WRAP:  cmd.wrap_en   = 1'b1;
            ST_DINIT: cmd.div_init  = 1'b1;
            ST_DIV:   cmd.div_step  = 1'b1;
            ST_DONE:  cmd.finish    = sts.out_free;
            default:  cmd.load      = 1'b0;
        endcase
    end

    `HECC_ASSERT(a_busy_after_req, in_valid && in_ready |=> !in_ready)
    `HECC_ASSERT(a_finish_free, cmd.finish |-> sts.out_free)
    `HECC_ASSERT(a_div_wrapped, cmd.div_step |-> sts.wrap_ok)
    `HECC_ASSERT(a_ready_idle, in_ready |-> state_reg == ST_IDLE)

endmodule

@@ src/hecc_dp.sv @@
// Datapath: products, shared CORDIC, angle wrap, scaling multiply and cue logic.
module hecc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hecc_pkg::cmd_t                   cmd,
    output hecc_pkg::sts_t                   sts,
    input  hecc_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output hecc_pkg::out_t                   out_data,
    input  logic                             cfg_valid,
    input  logic [hecc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hecc_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import hecc_pkg::*;

    localparam logic signed [ZW-1:0] Z_PI   = ZW'(ANG_PI);
    localparam logic signed [DW-1:0] D_PI   = DW'(ANG_PI);
    localparam logic signed [DW-1:0] D_2PI  = DW'(ANG_TWO_PI);
    localparam logic signed [CW-1:0] C_ONE  = CW'(1 << 28);

    // Configuration registers.
    logic [7:0]  left_idx_reg, right_idx_reg;
    logic        left_pres_reg, right_pres_reg;
    logic [15:0] repeat_reg;
    logic [14:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_idx_reg   <= '0;
            right_idx_reg  <= '0;
            left_pres_reg  <= 1'b0;
            right_pres_reg <= 1'b0;
            repeat_reg     <= 16'd5000;
            thr_reg        <= 15'd6434;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEFT_IDX:   left_idx_reg   <= cfg_data[7:0];
                REG_RIGHT_IDX:  right_idx_reg  <= cfg_data[7:0];
                REG_LEFT_PRES:  left_pres_reg  <= cfg_data[0];
                REG_RIGHT_PRES: right_pres_reg <= cfg_data[0];
                REG_REPEAT_MS:  repeat_reg     <= cfg_data;
                REG_THRESHOLD:  thr_reg        <= cfg_data[14:0];
                default:        repeat_reg     <= repeat_reg;
            endcase
        end
    end

    // Captured request.
    in_t in_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
    end

    // Quaternion products, one multiplier shared over the four products.
    logic signed [15:0] ma, mb;
    logic signed [31:0] prod;
    logic signed [32:0] acc_reg, sum33;
    logic signed [CW-1:0] s_reg, c_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            2'd0:    begin ma = in_reg.quat_w; mb = in_reg.quat_z; end
            2'd1:    begin ma = in_reg.quat_x; mb = in_reg.quat_y; end
            2'd2:    begin ma = in_reg.quat_y; mb = in_reg.quat_y; end
            default: begin ma = in_reg.quat_z; mb = in_reg.quat_z; end
        endcase
        prod  = ma * mb;
        sum33 = acc_reg + 33'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            if (!cmd.mul_sel[0])
            begin
                acc_reg <= 33'(prod);
            end
            else if (!cmd.mul_sel[1])
            begin
                s_reg <= {sum33, 1'b0};
            end
            else
            begin
                c_reg <= C_ONE - {sum33, 1'b0};
            end
        end
    end

    // Shared vectoring CORDIC.
    logic signed [CW-1:0] dx, dy, xi, yi;
    logic signed [XW-1:0] x_reg, y_reg, xs, ys;
    logic signed [ZW-1:0] z_reg, bearing_reg, atan_z;
    logic                 hold_reg;
    logic                 y_pos;

    assign dx = CW'(in_reg.target_x) - CW'(in_reg.robot_x);
    assign dy = CW'(in_reg.target_y) - CW'(in_reg.robot_y);
    assign xi = cmd.cord_sel ? c_reg : dx;
    assign yi = cmd.cord_sel ? s_reg : dy;
    assign xs = x_reg >>> cmd.cord_idx;
    assign ys = y_reg >>> cmd.cord_idx;
    assign y_pos = !y_reg[XW-1] && (y_reg != '0);
    assign atan_z = $signed({4'b0, atan_q16(cmd.cord_idx)});

    always_ff @(posedge clk)
    begin
        if (cmd.cord_init)
        begin
            if (cmd.cord_sel)
            begin
                bearing_reg <= z_reg;
            end
            hold_reg <= (yi == '0);
            if (yi == '0)
            begin
                z_reg <= xi[CW-1] ? Z_PI : '0;
            end
            else if (xi[CW-1])
            begin
                z_reg <= yi[CW-1] ? -Z_PI : Z_PI;
                x_reg <= -XW'(xi);
                y_reg <= -XW'(yi);
            end
            else
            begin
                z_reg <= '0;
                x_reg <= XW'(xi);
                y_reg <= XW'(yi);
            end
        end
        else if (cmd.cord_step && !hold_reg)
        begin
            if (y_pos)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_z;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_z;
            end
        end
    end

    // Heading difference and wrap into plus or minus pi.
    logic signed [DW-1:0] delta_reg;
    logic                 above, below;

    assign above = delta_reg > D_PI;
    assign below = delta_reg < -D_PI;
    assign sts.wrap_ok = !above && !below;

    always_ff @(posedge clk)
    begin
        if (cmd.delta_en)
        begin
            delta_reg <= DW'(bearing_reg) - DW'(z_reg);
        end
        else if (cmd.wrap_en)
        begin
            if (above)
            begin
                delta_reg <= delta_reg - D_2PI;
            end
            else if (below)
            begin
                delta_reg <= delta_reg + D_2PI;
            end
        end
    end

    // Scaling of |delta| * 255 by half pi in two steps: the first drops the
    // low five bits of the product, the second divides by 3217 through a
    // reciprocal multiply.
    logic [17:0]          mag;
    logic [25:0]          mag255;
    logic [20:0]          n_reg;
    logic [42:0]          recip_prod;
    logic [QW-1:0]        q_reg;
    logic                 neg_reg;

    assign mag        = delta_reg[DW-1] ? 18'(-delta_reg) : 18'(delta_reg);
    assign mag255     = (26'(mag) << 8) - 26'(mag);
    assign recip_prod = n_reg * DIV_RECIP;

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            n_reg   <= mag255[25:5];
            neg_reg <= delta_reg[DW-1];
        end
        else if (cmd.div_step)
        begin
            q_reg <= recip_prod[DIV_SHIFT +: QW];
        end
    end

    // Cue decision and repeat suppression.
    logic [7:0]           hmag;
    logic signed [8:0]    h;
    logic signed [DW-1:0] thr;
    logic [1:0]           cue;
    logic [7:0]           idx;
    logic                 pres, fire;
    logic [1:0]           last_cue_reg;
    logic [31:0]          last_time_reg, elapsed;
    logic                 out_valid_reg;
    out_t                 out_reg;

    always_comb
    begin
        hmag = (q_reg > QW'(255)) ? 8'd255 : q_reg[7:0];
        h    = neg_reg ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
        thr  = $signed(DW'({thr_reg, 3'b000}));
        if (delta_reg > thr)
        begin
            cue = CUE_LEFT;
        end
        else if (delta_reg < -thr)
        begin
            cue = CUE_RIGHT;
        end
        else
        begin
            cue = CUE_NONE;
        end
        idx     = (cue == CUE_LEFT) ? left_idx_reg : right_idx_reg;
        pres    = (cue == CUE_LEFT) ? left_pres_reg : right_pres_reg;
        elapsed = in_reg.now_ms - last_time_reg;
        fire    = in_reg.have_target && (cue != CUE_NONE) && pres &&
                  ((cue != last_cue_reg) || (elapsed > {16'd0, repeat_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cue_reg  <= CUE_NONE;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (fire)
                begin
                    last_cue_reg  <= cue;
                    last_time_reg <= in_reg.now_ms;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.haptic_level <= in_reg.have_target ? h : '0;
            out_reg.sound_index  <= fire ? idx : 8'd0;
            out_reg.cue_fired    <= fire;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

endmodule

@@ src/heading_error_haptic_cue_core.sv @@
// Top level of the heading error haptic cue block.
// Usage: a request on the input channel carries a target point, the robot
// pose as position and orientation quaternion, and a millisecond timestamp.
// The block answers every request with exactly one result on the output
// channel: a signed haptic level, a cue sound index and a fired flag.
// Both channels use valid and ready; configuration registers are written
// through a separate valid and ready channel that is always ready, and they
// should be written only while no request is in flight.
// A request passes through the four quaternion products on one shared
// multiplier, two passes of the shared CORDIC unit, the heading difference,
// its wrap into plus or minus pi, the scaling by a reciprocal multiply and
// the load of the output register. One request is processed at a time, and
// the sequencer passes through its idle state before it takes the next.
// The result sits in an output register, and the next request is taken
// while it waits. When the receiver stalls, a finished result holds in the
// sequencer until the output register frees up, and no request is taken.
// Reset clears the cue history and loads the register defaults (repeat
// interval 5000 ms, threshold 6434); no clearing pass is needed.
module heading_error_haptic_cue_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  hecc_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output hecc_pkg::out_t                 out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hecc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hecc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import hecc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Register writes are accepted directly, so the port never stalls.
    assign cfg_ready = 1'b1;

    hecc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hecc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
